[hw/rtl/kclc_pkg.sv]
`default_nettype none
package kclc_pkg;

	localparam int CODE_W      = 24;
	localparam int KEY_W       = 4;
	localparam int TRIES_W     = 4;
	localparam int COUNT_W     = 3;
	localparam int STATUS_W    = 3;
	localparam int KIND_W      = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 16;

	// Number of key digits in one code entry (1 to 6).
	localparam int CODE_DIGITS = 6;

	localparam logic [CODE_W-1:0]  USER_CODE_RST     = 24'h000000;
	localparam logic [CODE_W-1:0]  RECOVERY_CODE_RST = 24'h111111;
	localparam logic [TRIES_W-1:0] MAX_TRIES_RST     = 4'd3;
	localparam logic [TRIES_W-1:0] TRIES_SAT         = 4'd15;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_USER_CODE     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY_CODE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRIES     = 2'd2;

	// Event kinds.
	localparam logic [KIND_W-1:0] KIND_KEY     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REARM   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DIGIT_TAKEN = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNLOCKED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_WRONG_RETRY = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOCKED_OUT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REC_WRONG   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REC_OK      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd6;

	typedef struct packed {
		logic [CODE_W-1:0]  user_code;
		logic [CODE_W-1:0]  recovery_code;
		logic [TRIES_W-1:0] max_tries;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] digit_count;
		logic               mismatch_seen;
		logic [TRIES_W-1:0] wrong_tries;
		logic               lockout_flag;
		logic               open_flag;
		logic               timeout_flag;
	} lock_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic              recovery_mode;
	} event_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  digits_entered;
		logic [TRIES_W-1:0]  tries_left;
		logic                unlocked;
		logic                locked_out;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/kclc_cfg_regs.sv]
`default_nettype none
module kclc_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [kclc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [kclc_pkg::CODE_W-1:0]         cfg_wdata,
	output kclc_pkg::cfg_t                           cfg
);

	kclc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.user_code     <= kclc_pkg::USER_CODE_RST;
			cfg_q.recovery_code <= kclc_pkg::RECOVERY_CODE_RST;
			cfg_q.max_tries     <= kclc_pkg::MAX_TRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kclc_pkg::REG_USER_CODE:     cfg_q.user_code     <= cfg_wdata;
				kclc_pkg::REG_RECOVERY_CODE: cfg_q.recovery_code <= cfg_wdata;
				kclc_pkg::REG_MAX_TRIES:     cfg_q.max_tries     <= cfg_wdata[kclc_pkg::TRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/kclc_step.sv]
`default_nettype none
module kclc_step #(
	parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS
) (
	input  wire kclc_pkg::cfg_t        cfg,
	input  wire kclc_pkg::lock_state_t cur,
	input  wire kclc_pkg::event_t      ev,
	output kclc_pkg::lock_state_t      nxt,
	output kclc_pkg::result_t          res
);

	logic                          blocked;
	logic [kclc_pkg::CODE_W-1:0]   code;
	logic [4:0]                    shamt;
	logic [kclc_pkg::CODE_W-1:0]   shifted;
	logic [kclc_pkg::KEY_W-1:0]    nibble;
	logic [kclc_pkg::COUNT_W-1:0]  count_inc;
	logic                          good;
	logic [kclc_pkg::TRIES_W-1:0]  wrong_inc;
	logic [kclc_pkg::STATUS_W-1:0] status;

	// The first digit sits in the high nibble of the code.
	assign code      = ev.recovery_mode ? cfg.recovery_code : cfg.user_code;
	assign shamt     = 5'd20 - {cur.digit_count, 2'b00};
	assign shifted   = code >> shamt;
	assign nibble    = shifted[kclc_pkg::KEY_W-1:0];
	assign count_inc = cur.digit_count + 3'd1;
	assign good      = !cur.mismatch_seen && (nibble == ev.key);
	assign wrong_inc = (cur.wrong_tries < kclc_pkg::TRIES_SAT) ?
		cur.wrong_tries + 4'd1 : cur.wrong_tries;
	assign blocked   = cur.open_flag ||
		(!ev.recovery_mode && (cur.lockout_flag || cur.timeout_flag));

	always_comb begin
		nxt    = cur;
		status = kclc_pkg::ST_IGNORED;
		unique case (ev.kind)
			kclc_pkg::KIND_TIMEOUT: begin
				nxt.timeout_flag = 1'b1;
				if (!ev.recovery_mode) begin
					nxt.digit_count   = '0;
					nxt.mismatch_seen = 1'b0;
				end
			end
			kclc_pkg::KIND_REARM: begin
				nxt.open_flag     = 1'b0;
				nxt.timeout_flag  = 1'b0;
				nxt.digit_count   = '0;
				nxt.mismatch_seen = 1'b0;
			end
			kclc_pkg::KIND_KEY: begin
				if (!blocked) begin
					if (count_inc < kclc_pkg::COUNT_W'(CODE_DIGITS)) begin
						nxt.digit_count   = count_inc;
						nxt.mismatch_seen = !good;
						status            = kclc_pkg::ST_DIGIT_TAKEN;
					end else begin
						nxt.digit_count   = '0;
						nxt.mismatch_seen = 1'b0;
						if (ev.recovery_mode) begin
							if (good) begin
								nxt.open_flag    = 1'b1;
								nxt.lockout_flag = 1'b0;
								nxt.wrong_tries  = '0;
								status           = kclc_pkg::ST_REC_OK;
							end else begin
								status = kclc_pkg::ST_REC_WRONG;
							end
						end else if (good) begin
							nxt.open_flag   = 1'b1;
							nxt.wrong_tries = '0;
							status          = kclc_pkg::ST_UNLOCKED;
						end else begin
							nxt.wrong_tries = wrong_inc;
							if (wrong_inc >= cfg.max_tries) begin
								nxt.lockout_flag = 1'b1;
								status           = kclc_pkg::ST_LOCKED_OUT;
							end else begin
								status = kclc_pkg::ST_WRONG_RETRY;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.status         = status;
		res.digits_entered = nxt.digit_count;
		res.tries_left     = (cfg.max_tries > nxt.wrong_tries) ?
			cfg.max_tries - nxt.wrong_tries : '0;
		res.unlocked       = nxt.open_flag;
		res.locked_out     = nxt.lockout_flag;
	end

endmodule
`default_nettype wire

[hw/rtl/keypad_code_lock_controller_top.sv]
// Keypad code lock controller.
// An accepted word goes through the input register, then the step logic, and its result
// is then held in the result register, valid on the master side.
// Throughput: one word per cycle while the result side keeps tready high.
// Reset: arst_n clears the lock state and both registers' valid bits at once and
// loads the configuration defaults; no clearing pass is needed.
`default_nettype none
module keypad_code_lock_controller_top #(
	parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [kclc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [kclc_pkg::CODE_W-1:0]          cfg_wdata,
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [kclc_pkg::IN_DATA_W-1:0]       s_tdata,  // key[3:0], recovery_mode[4], zero pad
	input  wire logic [kclc_pkg::KIND_W-1:0]          s_tuser,  // kind[1:0]
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	// status[2:0], digits_entered[5:3], tries_left[9:6], unlocked[10],
	// locked_out[11], zero pad
	output      logic [kclc_pkg::OUT_DATA_W-1:0]      m_tdata
);

	kclc_pkg::cfg_t        cfg;
	kclc_pkg::lock_state_t state_q;
	kclc_pkg::lock_state_t state_nxt;
	kclc_pkg::event_t      ev_s1;
	kclc_pkg::result_t     res_nxt;
	kclc_pkg::result_t     res_q;
	logic                  valid_s1;
	logic                  out_valid_q;
	logic                  advance;

	kclc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kclc_step #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_step (
		.cfg (cfg),
		.cur (state_q),
		.ev  (ev_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// The input word moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_s1.kind          <= s_tuser;
			ev_s1.key           <= s_tdata[kclc_pkg::KEY_W-1:0];
			ev_s1.recovery_mode <= s_tdata[kclc_pkg::KEY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.locked_out, res_q.unlocked, res_q.tries_left,
		res_q.digits_entered, res_q.status};

`ifndef SYNTHESIS
	// Lockout is only set from a closed lock, and recovery clears it when opening.
	a_open_excl_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.open_flag && state_q.lockout_flag))
		else $error("lock open and locked out at once");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digit_count < kclc_pkg::COUNT_W'(CODE_DIGITS))
		else $error("digit count past code length");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("lock state changed without a word moving");

	a_lockout_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.status == kclc_pkg::ST_LOCKED_OUT) |->
		res_q.locked_out && (res_q.tries_left == '0))
		else $error("lockout result without lockout state");
`endif

endmodule
`default_nettype wire
